@@ src/fz_pkg.sv @@
// shared types, constants and rule tables for the fuzzy obstacle avoidance controller
// no dependencies
package fz_pkg;

  localparam int DistW   = 16;
  localparam int EdgeW   = 11;
  localparam int CtrW    = 8;
  localparam int MembW   = 16;
  localparam int FracW   = 15;
  localparam int SumW    = 20;
  localparam int AccW    = 28;
  localparam int SpeedW  = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 11;

  localparam logic [DistW-1:0] DistLimit   = 16'd2000;
  localparam logic [EdgeW-1:0] DistClamped = 11'd1900;
  localparam logic [MembW-1:0] OneQ15      = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_FALL_START  = 3'd0,
    REG_LOW_FALL_END    = 3'd1,
    REG_HIGH_RISE_START = 3'd2,
    REG_HIGH_RISE_END   = 3'd3,
    REG_CENTER_SLOW     = 3'd4,
    REG_CENTER_MEDIUM   = 3'd5,
    REG_CENTER_FAST     = 3'd6
  } cfg_reg_e;

  // how a membership is formed from the segment dividers
  typedef enum logic [2:0] {
    MS_ZERO   = 3'd0,
    MS_ONE    = 3'd1,
    MS_RISE_A = 3'd2,
    MS_FALL_A = 3'd3,
    MS_RISE_B = 3'd4,
    MS_FALL_B = 3'd5
  } memb_sel_e;

  // speed labels: 0 slow, 1 medium, 2 fast; index left*9 + front*3 + right
  localparam logic [1:0] RuleLeft [27] = '{
    2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1
  };
  localparam logic [1:0] RuleRight [27] = '{
    2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0,
    2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1
  };

endpackage

@@ src/fz_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
// no dependencies; the remainder entering must be below the divisor
module fz_div_pipe #(
  parameter int LANES = 1,
  parameter int QW    = 15,
  parameter int DW    = 11,
  parameter int SW    = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [DW-1:0] rem_i  [LANES],
  input  logic [QW-1:0] bits_i [LANES],
  input  logic [DW-1:0] den_i  [LANES],
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  output logic [QW-1:0] quot_o [LANES],
  output logic [DW-1:0] rem_o  [LANES],
  output logic [SW-1:0] side_o
);

  logic          st_valid [QW+1];
  logic [DW-1:0] st_rem   [QW+1][LANES];
  logic [QW-1:0] st_bits  [QW+1][LANES];
  logic [QW-1:0] st_quot  [QW+1][LANES];
  logic [DW-1:0] st_den   [QW+1][LANES];
  logic [SW-1:0] st_side  [QW+1];

  assign st_valid[0] = in_valid_i;
  assign st_side[0]  = side_i;
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign st_rem[0][l]  = rem_i[l];
    assign st_bits[0][l] = bits_i[l];
    assign st_quot[0][l] = '0;
    assign st_den[0][l]  = den_i[l];
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          valid_q;
    logic [SW-1:0] side_q;
    logic [DW-1:0] rem_q  [LANES];
    logic [DW-1:0] rem_d  [LANES];
    logic [QW-1:0] bits_q [LANES];
    logic [QW-1:0] quot_q [LANES];
    logic [QW-1:0] quot_d [LANES];
    logic [DW-1:0] den_q  [LANES];

    always_comb begin
      logic [DW:0] shifted;
      logic [DW:0] diff;
      for (int l = 0; l < LANES; l++) begin
        shifted = {st_rem[s][l], st_bits[s][l][QW-1]};
        diff    = shifted - {1'b0, st_den[s][l]};
        if (shifted >= {1'b0, st_den[s][l]}) begin
          rem_d[l]  = diff[DW-1:0];
          quot_d[l] = {st_quot[s][l][QW-2:0], 1'b1};
        end else begin
          rem_d[l]  = shifted[DW-1:0];
          quot_d[l] = {st_quot[s][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else begin
        valid_q <= st_valid[s];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q <= st_side[s];
      for (int l = 0; l < LANES; l++) begin
        rem_q[l]  <= rem_d[l];
        quot_q[l] <= quot_d[l];
        bits_q[l] <= {st_bits[s][l][QW-2:0], 1'b0};
        den_q[l]  <= st_den[s][l];
      end
    end

    assign st_valid[s+1] = valid_q;
    assign st_side[s+1]  = side_q;
    for (genvar l = 0; l < LANES; l++) begin : g_out
      assign st_rem[s+1][l]  = rem_q[l];
      assign st_bits[s+1][l] = bits_q[l];
      assign st_quot[s+1][l] = quot_q[l];
      assign st_den[s+1][l]  = den_q[l];
    end
  end

  assign out_valid_o = st_valid[QW];
  assign side_o      = st_side[QW];
  for (genvar l = 0; l < LANES; l++) begin : g_res
    assign quot_o[l] = st_quot[QW][l];
    assign rem_o[l]  = st_rem[QW][l];
  end

endmodule

@@ src/fuzzy_obstacle_avoid_controller_top.sv @@
// fuzzy obstacle avoidance controller: fuzzify, rule strengths, weighted average
// depends on fz_pkg and fz_div_pipe
//
// usage: drive left/front/right distances with start_i high for one cycle;
// busy_o is always low, so a new transaction may start in every cycle.
// results come out in order, each on left_speed_o, right_speed_o and
// no_rule_fired_o for exactly one cycle with done_o high.
// from the accepting edge to the edge that takes the result, a transaction passes
// one input stage, 15 stages of the membership divider (one quotient bit
// each), membership, minimum, two sum stages, multiply and add stages,
// 16 stages of the output divider and the output register.
// throughput is one transaction per cycle, set by the fully pipelined
// dividers.
// the receiver cannot stall; results are simply presented once.
// reset clears all valid bits and loads the default edges and centres.
// configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at
// once and must only happen while no transaction is in flight.
module fuzzy_obstacle_avoid_controller_top
  import fz_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [DistW-1:0]    left_distance_i,
  input  logic [DistW-1:0]    front_distance_i,
  input  logic [DistW-1:0]    right_distance_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output logic                done_o,
  output logic [SpeedW-1:0]   left_speed_o,
  output logic [SpeedW-1:0]   right_speed_o,
  output logic                no_rule_fired_o
);

  // configuration registers
  logic [EdgeW-1:0] edge_a_q, edge_b_q, edge_c_q, edge_d_q;
  logic [CtrW-1:0]  ctr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_a_q <= 11'd250;
      edge_b_q <= 11'd400;
      edge_c_q <= 11'd500;
      edge_d_q <= 11'd650;
      ctr_q[0] <= 8'd50;
      ctr_q[1] <= 8'd112;
      ctr_q[2] <= 8'd175;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW_FALL_START:  edge_a_q <= cfg_data_i;
        REG_LOW_FALL_END:    edge_b_q <= cfg_data_i;
        REG_HIGH_RISE_START: edge_c_q <= cfg_data_i;
        REG_HIGH_RISE_END:   edge_d_q <= cfg_data_i;
        REG_CENTER_SLOW:     ctr_q[0] <= cfg_data_i[CtrW-1:0];
        REG_CENTER_MEDIUM:   ctr_q[1] <= cfg_data_i[CtrW-1:0];
        REG_CENTER_FAST:     ctr_q[2] <= cfg_data_i[CtrW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // input stage: clamp, pick segments, set up divider operands
  logic [DistW-1:0] dist_in [3];
  assign dist_in[0] = left_distance_i;
  assign dist_in[1] = front_distance_i;
  assign dist_in[2] = right_distance_i;

  logic             s0_valid_q;
  logic [EdgeW-1:0] s0_num_q [6];
  logic [EdgeW-1:0] s0_den_q [6];
  logic [FracW-1:0] s0_zero_q [6];
  logic [26:0]      s0_sel_q;
  logic [EdgeW-1:0] s0_num_d [6];
  logic [EdgeW-1:0] s0_den_d [6];
  logic [26:0]      s0_sel_d;

  always_comb begin
    logic [EdgeW-1:0] x;
    memb_sel_e        sl, sm, sh;
    for (int d = 0; d < 3; d++) begin
      x = (dist_in[d] > DistLimit) ? DistClamped : dist_in[d][EdgeW-1:0];

      if (x <= edge_a_q)      sl = MS_ONE;
      else if (x >= edge_b_q) sl = MS_ZERO;
      else                    sl = MS_FALL_A;

      if (x <= edge_a_q)      sm = MS_ZERO;
      else if (x < edge_b_q)  sm = MS_RISE_A;
      else if (x <= edge_c_q) sm = MS_ONE;
      else if (x < edge_d_q)  sm = MS_FALL_B;
      else                    sm = MS_ZERO;

      if (x <= edge_c_q)      sh = MS_ZERO;
      else if (x < edge_d_q)  sh = MS_RISE_B;
      else                    sh = MS_ONE;

      // segment dividers only matter strictly inside their segment
      if (x > edge_a_q && x < edge_b_q) begin
        s0_num_d[2*d] = x - edge_a_q;
        s0_den_d[2*d] = edge_b_q - edge_a_q;
      end else begin
        s0_num_d[2*d] = '0;
        s0_den_d[2*d] = 11'd1;
      end
      if (x > edge_c_q && x < edge_d_q) begin
        s0_num_d[2*d+1] = x - edge_c_q;
        s0_den_d[2*d+1] = edge_d_q - edge_c_q;
      end else begin
        s0_num_d[2*d+1] = '0;
        s0_den_d[2*d+1] = 11'd1;
      end
      s0_sel_d[9*d +: 9] = {sh, sm, sl};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_sel_q <= s0_sel_d;
    for (int l = 0; l < 6; l++) begin
      s0_num_q[l]  <= s0_num_d[l];
      s0_den_q[l]  <= s0_den_d[l];
      s0_zero_q[l] <= '0;
    end
  end

  // membership dividers: lanes 2d and 2d+1 are segments a-b and c-d of distance d
  logic             md_valid;
  logic [FracW-1:0] md_quot [6];
  logic [EdgeW-1:0] md_rem  [6];
  logic [26:0]      md_sel;

  fz_div_pipe #(
    .LANES (6),
    .QW    (FracW),
    .DW    (EdgeW),
    .SW    (27)
  ) u_memb_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_valid_q),
    .rem_i       (s0_num_q),
    .bits_i      (s0_zero_q),
    .den_i       (s0_den_q),
    .side_i      (s0_sel_q),
    .out_valid_o (md_valid),
    .quot_o      (md_quot),
    .rem_o       (md_rem),
    .side_o      (md_sel)
  );

  // memberships; falling edge is the complement of the rising quotient
  logic             m_valid_q;
  logic [MembW-1:0] memb_q [3][3];
  logic [MembW-1:0] memb_d [3][3];

  always_comb begin
    logic [MembW-1:0] rise_a, fall_a, rise_b, fall_b;
    memb_sel_e        sel;
    for (int d = 0; d < 3; d++) begin
      rise_a = {1'b0, md_quot[2*d]};
      fall_a = OneQ15 - rise_a - {15'd0, (md_rem[2*d] != '0)};
      rise_b = {1'b0, md_quot[2*d+1]};
      fall_b = OneQ15 - rise_b - {15'd0, (md_rem[2*d+1] != '0)};
      for (int t = 0; t < 3; t++) begin
        sel = memb_sel_e'(md_sel[9*d+3*t +: 3]);
        unique case (sel)
          MS_ZERO:   memb_d[d][t] = '0;
          MS_ONE:    memb_d[d][t] = OneQ15;
          MS_RISE_A: memb_d[d][t] = rise_a;
          MS_FALL_A: memb_d[d][t] = fall_a;
          MS_RISE_B: memb_d[d][t] = rise_b;
          MS_FALL_B: memb_d[d][t] = fall_b;
          default:   memb_d[d][t] = '0;
        endcase
      end
    end
  end

  // rule strengths
  logic             w_valid_q;
  logic [MembW-1:0] w_q [27];
  logic [MembW-1:0] w_d [27];

  always_comb begin
    logic [MembW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          t = (memb_q[0][i] < memb_q[1][j]) ? memb_q[0][i] : memb_q[1][j];
          w_d[i*9+j*3+k] = (t < memb_q[2][k]) ? t : memb_q[2][k];
        end
      end
    end
  end

  // partial sums per left label group, per speed label
  logic            g_valid_q;
  logic [SumW-1:0] gl_q [3][3];
  logic [SumW-1:0] gr_q [3][3];
  logic [SumW-1:0] gl_d [3][3];
  logic [SumW-1:0] gr_d [3][3];

  always_comb begin
    int idx;
    for (int i = 0; i < 3; i++) begin
      for (int l = 0; l < 3; l++) begin
        gl_d[i][l] = '0;
        gr_d[i][l] = '0;
      end
      for (int r = 0; r < 9; r++) begin
        idx = i*9 + r;
        for (int l = 0; l < 3; l++) begin
          if (RuleLeft[idx] == l[1:0])  gl_d[i][l] = gl_d[i][l] + {4'd0, w_q[idx]};
          if (RuleRight[idx] == l[1:0]) gr_d[i][l] = gr_d[i][l] + {4'd0, w_q[idx]};
        end
      end
    end
  end

  // label weights and total strength
  logic            t_valid_q;
  logic [SumW-1:0] wl_q [3];
  logic [SumW-1:0] wr_q [3];
  logic [SumW-1:0] tot_q;
  logic [SumW-1:0] wl_d [3];
  logic [SumW-1:0] wr_d [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      wl_d[l] = gl_q[0][l] + gl_q[1][l] + gl_q[2][l];
      wr_d[l] = gr_q[0][l] + gr_q[1][l] + gr_q[2][l];
    end
  end

  // products of label weight and centre
  logic            p_valid_q;
  logic [AccW-1:0] pl_q [3];
  logic [AccW-1:0] pr_q [3];
  logic [SumW-1:0] ptot_q;

  // accumulated numerators
  logic            a_valid_q;
  logic [AccW-1:0] accl_q, accr_q;
  logic [SumW-1:0] atot_q;
  logic [AccW+1:0] accl_d, accr_d;

  assign accl_d = {2'd0, pl_q[0]} + {2'd0, pl_q[1]} + {2'd0, pl_q[2]};
  assign accr_d = {2'd0, pr_q[0]} + {2'd0, pr_q[1]} + {2'd0, pr_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      t_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      m_valid_q <= md_valid;
      w_valid_q <= m_valid_q;
      g_valid_q <= w_valid_q;
      t_valid_q <= g_valid_q;
      p_valid_q <= t_valid_q;
      a_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    memb_q <= memb_d;
    w_q    <= w_d;
    gl_q   <= gl_d;
    gr_q   <= gr_d;
    wl_q   <= wl_d;
    wr_q   <= wr_d;
    tot_q  <= wl_d[0] + wl_d[1] + wl_d[2];
    for (int l = 0; l < 3; l++) begin
      pl_q[l] <= wl_q[l] * ctr_q[l];
      pr_q[l] <= wr_q[l] * ctr_q[l];
    end
    ptot_q <= tot_q;
    // the weighted sum stays at most 255 times the total, so it fits
    accl_q <= accl_d[AccW-1:0];
    accr_q <= accr_d[AccW-1:0];
    atot_q <= ptot_q;
  end

  // output dividers: (acc << 8) / total, quotient below 2^16
  logic [SumW-1:0]   od_rem  [2];
  logic [SpeedW-1:0] od_bits [2];
  logic [SumW-1:0]   od_den  [2];
  logic              od_zero;
  logic              od_valid;
  logic [SpeedW-1:0] od_quot [2];
  logic [0:0]        od_side;

  assign od_rem[0]  = accl_q[AccW-1:8];
  assign od_rem[1]  = accr_q[AccW-1:8];
  assign od_bits[0] = {accl_q[7:0], 8'd0};
  assign od_bits[1] = {accr_q[7:0], 8'd0};
  assign od_zero    = (atot_q == '0);
  // a zero total would divide by zero; the result is replaced anyway
  assign od_den[0]  = od_zero ? SumW'(1) : atot_q;
  assign od_den[1]  = od_zero ? SumW'(1) : atot_q;

  fz_div_pipe #(
    .LANES (2),
    .QW    (SpeedW),
    .DW    (SumW),
    .SW    (1)
  ) u_out_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid_q),
    .rem_i       (od_rem),
    .bits_i      (od_bits),
    .den_i       (od_den),
    .side_i      (od_zero),
    .out_valid_o (od_valid),
    .quot_o      (od_quot),
    .rem_o       (),
    .side_o      (od_side)
  );

  logic              done_q;
  logic [SpeedW-1:0] lspd_q, rspd_q;
  logic              nrf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= od_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    lspd_q <= od_side[0] ? '0 : od_quot[0];
    rspd_q <= od_side[0] ? '0 : od_quot[1];
    nrf_q  <= od_side[0];
  end

  assign done_o          = done_q;
  assign left_speed_o    = lspd_q;
  assign right_speed_o   = rspd_q;
  assign no_rule_fired_o = nrf_q;

endmodule
